>>> sv/ogic_pkg.sv
package ogic_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int CFG_W   = 7;
    localparam int CRD_W   = 11;
    localparam int IN_W    = 6;
    localparam int COUNT_W = 13;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        logic load_item;
        logic clr_wr;
        logic rd_land_cell;
        logic rd_land_nb;
        logic wr_new;
        logic rd_parent_nb;
        logic rd_parent_cur;
        logic rd_size_a;
        logic rd_size_b;
        logic union_wr;
        logic k_inc;
        logic finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic oor;
        logic land;
        logic nb_ok;
        logic at_root;
        logic same_set;
        logic k_last;
        logic out_free;
    } status_t;

endpackage

>>> sv/online_grid_island_counter.sv
// Channel | Word        | Bits
// s_axis  | cell coords | tdata[5:0] cell_row, tdata[11:6] cell_col
// m_axis  | count       | tdata[12:0] island_count, tuser[0] out_of_range
// cfg     | register    | cfg_index 0 grid_rows, 1 grid_cols, cfg_data[6:0]
//
// An out-of-range or already-land cell leaves the count as it is; a new cell is
// marked land and its neighbours are visited in turn: one outside the grid or water
// is skipped; for a land one the parent links are walked to its root and, if that
// root lies in another set, the two sets are merged.
// After reset a clearing pass wipes the land map; s_tready stays low until it ends.
// A stalled result waits in the output register; the next word is accepted meanwhile.
module online_grid_island_counter
#(
    parameter int MAX_ROWS = ogic_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = ogic_pkg::DEF_MAX_COLS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cell_row, cell_col
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // island_count
    output logic [0:0]  m_tuser,   // out_of_range
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    ogic_pkg::cmd_t    cmd;
    ogic_pkg::status_t sts;
    logic [ogic_pkg::COUNT_W-1:0] count;

    ogic_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ogic_dp
    #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_row    (s_tdata[5:0]),
        .in_col    (s_tdata[11:6]),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_count (count),
        .out_oor   (m_tuser[0])
    );

    assign m_tdata = {3'b000, count};

endmodule

>>> sv/ogic_ctrl.sv
module ogic_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ogic_pkg::status_t sts,
    output ogic_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_LCHK = 4'd3;
    localparam logic [3:0] S_NB   = 4'd4;
    localparam logic [3:0] S_NBL  = 4'd5;
    localparam logic [3:0] S_FIND = 4'd6;
    localparam logic [3:0] S_SZA  = 4'd7;
    localparam logic [3:0] S_SZB  = 4'd8;
    localparam logic [3:0] S_NEXT = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.oor)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.rd_land_cell = 1'b1;
                    state_next       = S_LCHK;
                end
            end
            S_LCHK:
            begin
                if (sts.land)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    state_next = S_NB;
                end
            end
            S_NB:
            begin
                if (sts.nb_ok)
                begin
                    cmd.rd_land_nb = 1'b1;
                    state_next     = S_NBL;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NBL:
            begin
                if (sts.land)
                begin
                    cmd.rd_parent_nb = 1'b1;
                    state_next       = S_FIND;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_FIND:
            begin
                if (!sts.at_root)
                begin
                    cmd.rd_parent_cur = 1'b1;
                end
                else if (sts.same_set)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.rd_size_a = 1'b1;
                    state_next    = S_SZA;
                end
            end
            S_SZA:
            begin
                cmd.rd_size_b = 1'b1;
                state_next    = S_SZB;
            end
            S_SZB:
            begin
                cmd.union_wr = 1'b1;
                state_next   = S_NEXT;
            end
            S_NEXT:
            begin
                cmd.k_inc  = 1'b1;
                state_next = sts.k_last ? S_FIN : S_NB;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/ogic_dp.sv
module ogic_dp
#(
    parameter int MAX_ROWS = ogic_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = ogic_pkg::DEF_MAX_COLS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ogic_pkg::CFG_W-1:0]    cfg_data,
    input  logic [ogic_pkg::IN_W-1:0]     in_row,
    input  logic [ogic_pkg::IN_W-1:0]     in_col,
    input  ogic_pkg::cmd_t                cmd,
    output ogic_pkg::status_t             sts,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [ogic_pkg::COUNT_W-1:0]  out_count,
    output logic                          out_oor
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int SW    = AW + 1;
    localparam int IW    = (AW + 1 > ogic_pkg::COUNT_W) ? AW + 1 : ogic_pkg::COUNT_W;
    localparam int CRW   = ogic_pkg::CRD_W;

    logic [ogic_pkg::CFG_W-1:0] rows_reg;
    logic [ogic_pkg::CFG_W-1:0] cols_reg;
    logic [CRW-1:0]             r_reg;
    logic [CRW-1:0]             c_reg;
    logic [1:0]                 k_reg;
    logic [AW-1:0]              rb_reg;
    logic [AW-1:0]              ra_reg;
    logic [AW-1:0]              cur_reg;
    logic [SW-1:0]              sza_reg;
    logic [2:0]                 merges_reg;
    logic [IW-1:0]              islands_reg;
    logic [AW-1:0]              clr_reg;
    logic                       out_valid_reg;
    logic [ogic_pkg::COUNT_W-1:0] out_count_reg;
    logic                       out_oor_reg;

    logic                       land_mem [0:DEPTH-1];
    logic [AW-1:0]              par_mem  [0:DEPTH-1];
    logic [SW-1:0]              size_mem [0:DEPTH-1];
    logic                       land_rd_reg;
    logic [AW-1:0]              par_rd_reg;
    logic [SW-1:0]              size_rd_reg;

    logic [CRW-1:0]             rows_eff;
    logic [CRW-1:0]             cols_eff;
    logic [CRW-1:0]             nr;
    logic [CRW-1:0]             nc;
    logic                       nb_edge;
    logic [AW-1:0]              cell_addr;
    logic [AW-1:0]              nb_addr;
    logic                       a_wins;
    logic [SW-1:0]              size_sum;
    logic [AW-1:0]              winner;
    logic [AW-1:0]              loser;

    always_comb
    begin
        rows_eff = (CRW'(rows_reg) > CRW'(MAX_ROWS)) ? CRW'(MAX_ROWS) : CRW'(rows_reg);
        cols_eff = (CRW'(cols_reg) > CRW'(MAX_COLS)) ? CRW'(MAX_COLS) : CRW'(cols_reg);
        nr       = r_reg;
        nc       = c_reg;
        nb_edge  = 1'b0;
        case (k_reg)
            2'd0:    nr = r_reg + CRW'(1);
            2'd1:    nc = c_reg + CRW'(1);
            2'd2:
            begin
                nr      = r_reg - CRW'(1);
                nb_edge = (r_reg == '0);
            end
            default:
            begin
                nc      = c_reg - CRW'(1);
                nb_edge = (c_reg == '0);
            end
        endcase
        cell_addr = {r_reg[RW-1:0], c_reg[CW-1:0]};
        nb_addr   = {nr[RW-1:0], nc[CW-1:0]};
        a_wins    = (sza_reg > size_rd_reg);
        size_sum  = sza_reg + size_rd_reg;
        winner    = a_wins ? ra_reg : rb_reg;
        loser     = a_wins ? rb_reg : ra_reg;
    end

    always_comb
    begin
        sts.clr_done = (clr_reg == {AW{1'b1}});
        sts.oor      = (r_reg >= rows_eff) || (c_reg >= cols_eff);
        sts.land     = land_rd_reg;
        sts.nb_ok    = !nb_edge && (nr < rows_eff) && (nc < cols_eff);
        sts.at_root  = (par_rd_reg == cur_reg);
        sts.same_set = (cur_reg == rb_reg);
        sts.k_last   = (k_reg == 2'd3);
        sts.out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            land_mem[clr_reg] <= 1'b0;
        end
        else if (cmd.wr_new)
        begin
            land_mem[cell_addr] <= 1'b1;
        end
        if (cmd.rd_land_cell || cmd.rd_land_nb)
        begin
            land_rd_reg <= land_mem[cmd.rd_land_cell ? cell_addr : nb_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_new)
        begin
            par_mem[cell_addr] <= cell_addr;
        end
        else if (cmd.union_wr)
        begin
            par_mem[loser] <= winner;
        end
        if (cmd.rd_parent_nb || cmd.rd_parent_cur)
        begin
            par_rd_reg <= par_mem[cmd.rd_parent_nb ? nb_addr : par_rd_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_new)
        begin
            size_mem[cell_addr] <= SW'(1);
        end
        else if (cmd.union_wr)
        begin
            size_mem[winner] <= size_sum;
        end
        if (cmd.rd_size_a || cmd.rd_size_b)
        begin
            size_rd_reg <= size_mem[cmd.rd_size_a ? cur_reg : rb_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            r_reg <= CRW'(in_row);
            c_reg <= CRW'(in_col);
        end
        if (cmd.rd_parent_nb)
        begin
            cur_reg <= nb_addr;
        end
        else if (cmd.rd_parent_cur)
        begin
            cur_reg <= par_rd_reg;
        end
        if (cmd.rd_size_a)
        begin
            ra_reg <= cur_reg;
        end
        if (cmd.rd_size_b)
        begin
            sza_reg <= size_rd_reg;
        end
        if (cmd.wr_new)
        begin
            rb_reg <= cell_addr;
        end
        else if (cmd.union_wr)
        begin
            rb_reg <= winner;
        end
        if (cmd.load_out)
        begin
            out_count_reg <= islands_reg[ogic_pkg::COUNT_W-1:0];
            out_oor_reg   <= sts.oor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= ogic_pkg::CFG_W'(64);
            cols_reg      <= ogic_pkg::CFG_W'(64);
            k_reg         <= '0;
            merges_reg    <= '0;
            islands_reg   <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == ogic_pkg::CFG_ROWS)
                begin
                    rows_reg <= cfg_data;
                end
                else
                begin
                    cols_reg <= cfg_data;
                end
            end
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.wr_new)
            begin
                k_reg      <= '0;
                merges_reg <= '0;
            end
            else
            begin
                if (cmd.k_inc)
                begin
                    k_reg <= k_reg + 2'd1;
                end
                if (cmd.union_wr)
                begin
                    merges_reg <= merges_reg + 3'd1;
                end
            end
            if (cmd.finish)
            begin
                islands_reg <= islands_reg + IW'(1) - IW'(merges_reg);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;
    assign out_oor   = out_oor_reg;

endmodule

>>> sv/ogic_checker.sv
module ogic_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after accept");

    a_busy_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ##1 !s_tready)
        else $error("ready two cycles after accept");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:13] == 3'b000))
        else $error("nonzero pad bits");

endmodule

bind online_grid_island_counter ogic_checker u_ogic_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
